/* hw/rtl/pcmcv_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the pcm s16 format converter
package pcmcv_pkg;

    // output format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S8  = 3'd1;
    localparam logic [2:0] FMT_U16 = 3'd2;
    localparam logic [2:0] FMT_S16 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;

    // channel mode codes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OUT_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_MODE = 2'd1;
    localparam logic [1:0] CFG_SWAP_BYTES   = 2'd2;

    // valid byte counts
    localparam logic [2:0] BYTES_1 = 3'd1;
    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_4 = 3'd4;

    // float exponent bases: 127 - 15 for a single sample, 127 - 16 for a pair sum
    localparam logic [7:0] EXP_BASE_MONO = 8'd112;
    localparam logic [7:0] EXP_BASE_PAIR = 8'd111;

    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               block_end;
    } t_in;

    typedef struct packed {
        logic [31:0] out_word;
        logic [2:0]  out_bytes;
        logic        last_of_run;
        logic        block_end_out;
    } t_out;

    typedef struct packed {
        logic [2:0] out_format;
        logic [1:0] channel_mode;
        logic       swap_bytes;
    } t_cfg;

    // after the adder stage
    typedef struct packed {
        logic [15:0] a;
        logic [16:0] s;
        logic        down;
        logic        be;
    } t_s1;

    // after the conversion stage
    typedef struct packed {
        logic [15:0] int_word;
        logic        sign;
        logic [16:0] mag;
        logic [4:0]  msb;
        logic        zero;
        logic        down;
        logic        be;
    } t_s2;

    // after the packing stage
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  bytes;
        logic        be;
    } t_s3;

endpackage

/* hw/rtl/pcmcv_add.sv */
`timescale 1ns / 1ps
// first stage: pair sum and mode capture
module pcmcv_add (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmcv_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  pcmcv_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pcmcv_pkg::t_s1    o_data
);
    import pcmcv_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.a    = i_data.sample_a;
        n_data.s    = {i_data.sample_a[15], i_data.sample_a}
                    + {i_data.sample_b[15], i_data.sample_b};
        n_data.down = (i_cfg.channel_mode == MODE_DOWN);
        n_data.be   = i_data.block_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/pcmcv_conv.sv */
`timescale 1ns / 1ps
// second stage: integer formats, float magnitude and leading one
module pcmcv_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmcv_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  pcmcv_pkg::t_s1    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pcmcv_pkg::t_s2    o_data
);
    import pcmcv_pkg::*;

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic [16:0] s_adj;
    logic [15:0] v_floor;
    logic [15:0] v_trunc;
    logic [16:0] n_val;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // halved pair, floored and truncated toward zero
        s_adj   = i_data.s + {16'b0, i_data.s[16]};
        v_floor = i_data.down ? i_data.s[16:1] : i_data.a;
        v_trunc = i_data.down ? s_adj[16:1]    : i_data.a;

        case (i_cfg.out_format)
            FMT_U8:  n_data.int_word = {8'b0, ~v_floor[15], v_floor[14:8]};
            FMT_S8:  n_data.int_word = {8'b0, v_floor[15:8]};
            FMT_U16: n_data.int_word = {~v_floor[15], v_floor[14:0]};
            default: n_data.int_word = v_trunc;
        endcase

        n_val        = i_data.down ? i_data.s : {i_data.a[15], i_data.a};
        n_data.sign  = n_val[16];
        n_data.mag   = n_val[16] ? (17'd0 - n_val) : n_val;
        n_data.zero  = (n_val == 17'd0);
        n_data.msb   = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (n_data.mag[i]) begin
                n_data.msb = 5'(i);
            end
        end
        n_data.down = i_data.down;
        n_data.be   = i_data.be;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/pcmcv_pack.sv */
`timescale 1ns / 1ps
// third stage: float normalise, word select and byte swap
module pcmcv_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmcv_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  pcmcv_pkg::t_s2    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pcmcv_pkg::t_s3    o_data
);
    import pcmcv_pkg::*;

    logic        r_valid;
    t_s3         r_data;
    t_s3         n_data;
    logic [16:0] norm;
    logic [7:0]  expo;
    logic [31:0] fbits;
    logic [15:0] w16;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // leading one moved to bit 16, the bits below it form the mantissa
        norm  = i_data.mag << (5'd16 - i_data.msb);
        expo  = (i_data.down ? EXP_BASE_PAIR : EXP_BASE_MONO) + {3'b0, i_data.msb};
        fbits = i_data.zero ? 32'd0 : {i_data.sign, expo, norm[15:0], 7'b0};
        w16   = i_data.int_word;

        case (i_cfg.out_format)
            FMT_U8, FMT_S8: begin
                n_data.word  = {16'b0, w16};
                n_data.bytes = BYTES_1;
            end
            FMT_F32: begin
                n_data.word  = i_cfg.swap_bytes
                             ? {fbits[7:0], fbits[15:8], fbits[23:16], fbits[31:24]}
                             : fbits;
                n_data.bytes = BYTES_4;
            end
            default: begin
                n_data.word  = {16'b0, (i_cfg.swap_bytes ? {w16[7:0], w16[15:8]} : w16)};
                n_data.bytes = BYTES_2;
            end
        endcase
        n_data.be = i_data.be;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/pcmcv_out.sv */
`timescale 1ns / 1ps
// output register with upmix repeat
module pcmcv_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmcv_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  pcmcv_pkg::t_s3    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pcmcv_pkg::t_out   o_data
);
    import pcmcv_pkg::*;

    logic r_valid;
    logic r_rem;   // a further copy follows the one shown
    t_s3  r_data;

    assign o_ready = !r_valid || (i_ready && !r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_rem   <= (i_cfg.channel_mode == MODE_UP);
        end else if (i_ready) begin
            if (r_rem) begin
                r_rem <= 1'b0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid              = r_valid;
    assign o_data.out_word      = r_data.word;
    assign o_data.out_bytes     = r_data.bytes;
    assign o_data.last_of_run   = !r_rem;
    assign o_data.block_end_out = !r_rem && r_data.be;
endmodule

/* hw/rtl/pcm_s16_format_converter.sv */
`timescale 1ns / 1ps
// top level of the pcm s16 format converter
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_ready    i_in  (sample_a, sample_b, block_end)
//   output    o_out_valid / i_out_ready  o_out (out_word, out_bytes, last_of_run,
//                                              block_end_out)
//   config    i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// four register stages: pair sum, conversion with leading-one search,
// float normalise and byte swap, then the output register
// one request per cycle in pass and downmix modes while the output is ready; upmix gives two
// results per request, so the output register takes a new request only once both are taken
// each stage holds its request while the next one is full, nothing is lost
// synchronous active-low reset clears valid bits and sets the config to
// signed 16, per sample, no swap
module pcm_s16_format_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pcmcv_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pcmcv_pkg::t_out   o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [2:0]        i_cfg_wdata
);
    import pcmcv_pkg::*;

    t_cfg r_cfg;

    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;
    t_s1  s1_data;
    t_s2  s2_data;
    t_s3  s3_data;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_format   <= FMT_S16;
            r_cfg.channel_mode <= MODE_PASS;
            r_cfg.swap_bytes   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUT_FORMAT:   r_cfg.out_format   <= i_cfg_wdata;
                CFG_CHANNEL_MODE: r_cfg.channel_mode <= i_cfg_wdata[1:0];
                CFG_SWAP_BYTES:   r_cfg.swap_bytes   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // pair sum
    pcmcv_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // integer formats and float magnitude
    pcmcv_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // float assembly and byte order
    pcmcv_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // output register, repeats the result in upmix mode
    pcmcv_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );
endmodule

/* test/pcmcv_result_checker.sv */
`timescale 1ns / 1ps
// result checker: watches both channels, predicts each result and compares it
module pcmcv_result_checker
    import pcmcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_wdata,
    output int          o_pending,
    output int          o_fail_count
);

    t_cfg cfg_q;
    t_out expected_q[$];
    int   n_fail = 0;
    int   n_printed = 0;
    int   n_pending = 0;

    assign o_pending    = n_pending;
    assign o_fail_count = n_fail;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_fail++;
        if (n_printed < 100) begin
            n_printed++;
            $display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
        end
    endtask

    // exact ieee single bits of n / 2^k
    function automatic logic [31:0] float_bits(input int n, input int k);
        logic        sgn;
        logic [31:0] mag;
        logic [31:0] shifted;
        int          msb;
        int          expo;
        if (n == 0)
            return 32'd0;
        sgn = (n < 0);
        mag = sgn ? -n : n;
        msb = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                msb = i;
        expo    = 127 + msb - k;
        shifted = mag << (23 - msb);
        return {sgn, expo[7:0], shifted[22:0]};
    endfunction

    // converted word and byte count for one request under the given settings
    function automatic t_out convert_request(input t_in req, input t_cfg c);
        t_out        r;
        int          a;
        int          b;
        int          t;
        logic        down;
        logic [31:0] w;
        a    = {{16{req.sample_a[15]}}, req.sample_a};
        b    = {{16{req.sample_b[15]}}, req.sample_b};
        down = (c.channel_mode == MODE_DOWN);
        r    = '0;
        case (c.out_format)
            FMT_U8: begin
                t = a + 32768;
                if (down)
                    t = (t + b + 32768) >>> 1;
                w = {24'd0, t[15:8]};
                r.out_bytes = BYTES_1;
            end
            FMT_S8: begin
                t = down ? ((a + b) >>> 1) : a;
                t = t >>> 8;
                w = {24'd0, t[7:0]};
                r.out_bytes = BYTES_1;
            end
            FMT_U16: begin
                t = a + 32768;
                if (down)
                    t = (t + b + 32768) >>> 1;
                w = {16'd0, t[15:0]};
                if (c.swap_bytes)
                    w = {16'd0, w[7:0], w[15:8]};
                r.out_bytes = BYTES_2;
            end
            FMT_F32: begin
                w = down ? float_bits(a + b, 16) : float_bits(a, 15);
                if (c.swap_bytes)
                    w = {w[7:0], w[15:8], w[23:16], w[31:24]};
                r.out_bytes = BYTES_4;
            end
            default: begin
                // signed 16, and the unassigned codes
                t = down ? (a + b) / 2 : a;
                w = {16'd0, t[15:0]};
                if (c.swap_bytes)
                    w = {16'd0, w[7:0], w[15:8]};
                r.out_bytes = BYTES_2;
            end
        endcase
        r.out_word = w;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out base;
        if (!i_rst_n) begin
            cfg_q = '{out_format: FMT_S16, channel_mode: MODE_PASS, swap_bytes: 1'b0};
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", i_out.out_word, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.out_word !== want.out_word)
                        report_mismatch("out_word", i_out.out_word, want.out_word);
                    if (i_out.out_bytes !== want.out_bytes)
                        report_mismatch("out_bytes", 32'(i_out.out_bytes),
                                        32'(want.out_bytes));
                    if (i_out.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(i_out.last_of_run),
                                        32'(want.last_of_run));
                    if (i_out.block_end_out !== want.block_end_out)
                        report_mismatch("block_end_out", 32'(i_out.block_end_out),
                                        32'(want.block_end_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                base = convert_request(i_in, cfg_q);
                if (cfg_q.channel_mode == MODE_UP) begin
                    // first copy of an upmix pair carries no end flags
                    expected_q.push_back(base);
                end
                base.last_of_run   = 1'b1;
                base.block_end_out = i_in.block_end;
                expected_q.push_back(base);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUT_FORMAT:   cfg_q.out_format   = i_cfg_wdata;
                    CFG_CHANNEL_MODE: cfg_q.channel_mode = i_cfg_wdata[1:0];
                    CFG_SWAP_BYTES:   cfg_q.swap_bytes   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        n_pending = expected_q.size();
    end

endmodule

/* test/tb_pcm_s16_format_converter.sv */
`timescale 1ns / 1ps
// testbench top: stimulus, back-pressure and verdict for the pcm s16 format converter
module tb_pcm_s16_format_converter;
    import pcmcv_pkg::*;

    // watchdog, generous against the slowest legal run
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_REQUESTS = 1800;
    // receiver hold-off long enough to fill every stage
    localparam int LONG_HOLD       = 300;
    // register index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in        in_req;
    logic       out_valid;
    logic       out_ready;
    t_out       out_res;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [2:0] cfg_wdata;

    int         pending_cnt;
    int         fail_cnt;
    int         cycle_cnt = 0;

    // shared between sender and receiver
    logic       calm = 1'b0;      // no idling on either side in this phase
    logic       hold_req = 1'b0;  // asks the receiver for one long hold-off

    pcm_s16_format_converter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    pcmcv_result_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending_cnt),
        .o_fail_count (fail_cnt)
    );

    // 10 ns clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hang or a lost result ends the run here
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: random ready gaps per result, plus the long hold-off on request
    initial begin : result_sink
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = LONG_HOLD;
            end
            repeat (gap) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one request after a random gap and hold it until taken
    task automatic offer_request(input logic [15:0] a, input logic [15:0] b, input logic be);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= '{sample_a: a, sample_b: b, block_end: be};
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cnt != 0)
            @(negedge clk);
    endtask

    // one register write, enable high for a single edge
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // settings change only once the block has gone idle
    task automatic apply_config(input logic [2:0] fmt, input logic [2:0] mode,
                                input logic swap);
        drain_results();
        write_reg(CFG_OUT_FORMAT, fmt);
        write_reg(CFG_CHANNEL_MODE, mode);
        write_reg(CFG_SWAP_BYTES, {2'b00, swap});
    endtask

    // samples weighted towards full scale, zero and the sign boundary
    function automatic logic [15:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return {7'd0, r[8:0]} - 16'd256;
            default: return r[15:0];
        endcase
    endfunction

    initial begin : stimulus
        int          left;
        int          n;
        int          phase;
        int          pause_at;
        logic [2:0]  fmt;
        logic [2:0]  mode;
        logic        swap;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_OUT_FORMAT;
        cfg_wdata = 3'd0;

        // synchronous reset asserted first, then released
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, signed 16 per sample, full scale and around zero
        offer_request(16'h8000, 16'h1234, 1'b0);
        offer_request(16'h7FFF, 16'h0000, 1'b0);
        offer_request(16'h0000, 16'hFFFF, 1'b0);
        offer_request(16'hFFFF, 16'h7FFF, 1'b1);
        offer_request(16'h0001, 16'h8000, 1'b0);

        // float pair sums: minus one, near one, a zero sum giving plus zero, tiny values
        apply_config(FMT_F32, {1'b0, MODE_DOWN}, 1'b0);
        offer_request(16'h8000, 16'h8000, 1'b0);
        offer_request(16'h7FFF, 16'h7FFF, 1'b0);
        offer_request(16'h0001, 16'hFFFF, 1'b0);
        offer_request(16'hFFFF, 16'h0000, 1'b0);
        offer_request(16'h0001, 16'h0000, 1'b1);

        // signed 16 average truncates towards zero
        apply_config(FMT_S16, {1'b0, MODE_DOWN}, 1'b0);
        offer_request(16'hFFFF, 16'h0000, 1'b0);
        offer_request(16'hFFFD, 16'h0000, 1'b0);
        offer_request(16'h8000, 16'h8000, 1'b0);
        offer_request(16'h7FFF, 16'h7FFF, 1'b1);

        // unsigned 8 average of the offset samples
        apply_config(FMT_U8, {1'b0, MODE_DOWN}, 1'b0);
        offer_request(16'h8000, 16'h8001, 1'b0);
        offer_request(16'h7FFF, 16'h7FFE, 1'b0);

        // signed 8 floors, byte swap has no effect on 8-bit words
        apply_config(FMT_S8, {1'b0, MODE_DOWN}, 1'b1);
        offer_request(16'hFFFF, 16'h0000, 1'b0);
        offer_request(16'h8000, 16'h8000, 1'b0);
        offer_request(16'h0100, 16'h00FF, 1'b1);

        // upmix pair: end flags only on the second copy
        apply_config(FMT_U16, {1'b0, MODE_UP}, 1'b1);
        offer_request(16'h1234, 16'h0000, 1'b1);
        offer_request(16'h8000, 16'h0000, 1'b0);

        // swapped float words
        apply_config(FMT_F32, {1'b0, MODE_PASS}, 1'b1);
        offer_request(16'h8000, 16'h0000, 1'b0);
        offer_request(16'h4000, 16'h0000, 1'b0);

        // unassigned format and channel codes fall back to signed 16 per sample
        apply_config(3'd6, 3'd3, 1'b1);
        offer_request(16'h1234, 16'h5678, 1'b1);

        // a write to the spare index must change nothing, issued once idle
        drain_results();
        write_reg(CFG_SPARE, 3'd7);

        // random phases: first the extreme settings, then random ones
        left  = RANDOM_REQUESTS;
        phase = 0;
        while (left > 0) begin
            case (phase)
                0:       begin fmt = FMT_U8;  mode = {1'b0, MODE_PASS}; swap = 1'b0; end
                1:       begin fmt = 3'd7;    mode = 3'd3;              swap = 1'b1; end
                2:       begin fmt = FMT_F32; mode = {1'b0, MODE_DOWN}; swap = 1'b1; end
                3:       begin fmt = FMT_F32; mode = {1'b0, MODE_UP};   swap = 1'b0; end
                4:       begin fmt = FMT_U16; mode = {1'b0, MODE_DOWN}; swap = 1'b1; end
                5:       begin fmt = FMT_S8;  mode = {1'b0, MODE_UP};   swap = 1'b1; end
                default: begin
                    fmt  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
                    mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7))
                                                       : 3'($urandom_range(0, 2));
                    swap = 1'($urandom_range(0, 1));
                end
            endcase
            apply_config(fmt, mode, swap);

            n = $urandom_range(20, 100);
            if (n > left)
                n = left;
            calm = ($urandom_range(0, 3) == 0);

            // back-pressure phases: sender keeps offering while the receiver sits still
            if (phase == 2 || phase % 9 == 7) begin
                calm     = 1'b0;
                hold_req = 1'b1;
            end

            // now and then a mid-phase pause until the block is empty
            pause_at = ($urandom_range(0, 3) == 0) ? n / 2 : -1;

            for (int i = 0; i < n; i++) begin
                if (i == pause_at)
                    drain_results();
                offer_request(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0));
            end
            left -= n;
            phase++;
        end

        // let the pipeline empty, then a short settle for stray results
        drain_results();
        repeat (16) @(posedge clk);

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pcmcv_pkg.sv
hw/rtl/pcmcv_add.sv
hw/rtl/pcmcv_conv.sv
hw/rtl/pcmcv_pack.sv
hw/rtl/pcmcv_out.sv
hw/rtl/pcm_s16_format_converter.sv
test/pcmcv_result_checker.sv
test/tb_pcm_s16_format_converter.sv
